// ===== rtl/lspb_pkg.sv =====
// Package for the LED strip pixel buffer: operation and state types,
// configuration register indexes, field widths and the divide-by-255 helper.
// No dependencies.
package lspb_pkg;

    localparam int MAX_PIXELS_DEF = 64;
    localparam int OP_W           = 2;
    localparam int IDX_W          = 6;
    localparam int CNT_W          = 7;
    localparam int BYTE_W         = 8;
    localparam int PIX_W          = 3 * BYTE_W;
    localparam int PROD_W         = 2 * BYTE_W;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [CNT_W-1:0]  PIXELS_RST     = 7'd64;
    localparam logic [BYTE_W-1:0] BRIGHTNESS_RST = 8'd255;
    localparam logic [PROD_W-1:0] ROUND_ADD      = 16'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRB        = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_SET  = 2'd0,
        OP_GET  = 2'd1,
        OP_FILL = 2'd2,
        OP_SHOW = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_SHOW
    } t_state;

    // exact floor(x / 255) for 16-bit x up to 65279, where the quotient fits in 8 bits
    function automatic logic [BYTE_W-1:0] div255(input logic [PROD_W-1:0] x);
        logic [PROD_W-1:0] s;
        s = x + {{BYTE_W{1'b0}}, x[PROD_W-1:BYTE_W]} + PROD_W'(1);
        return s[PROD_W-1:BYTE_W];
    endfunction

endpackage

// ===== rtl/led_strip_pixel_buffer.sv =====
// LED strip pixel buffer: set, get, fill and show over a 24-bit pixel memory.
// Depends on lspb_pkg.
// Set and get: one item per cycle while idle and the output side is ready; the result passes
// the read, scale and output registers in turn. Fill: one memory write per cycle, one acknowledge item.
// Show: one memory read and one result per cycle over the active pixels while the
// output side is ready. Stalls set by the output register.
// Reset clears the per-entry valid bits, so the store reads black at once.
module led_strip_pixel_buffer #(
    parameter int MAX_PIXELS = lspb_pkg::MAX_PIXELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lspb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lspb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [lspb_pkg::OP_W-1:0]        i_operation,
    input  logic [lspb_pkg::IDX_W-1:0]       i_pixel_index,
    input  logic [lspb_pkg::BYTE_W-1:0]      i_red_value,
    input  logic [lspb_pkg::BYTE_W-1:0]      i_green_value,
    input  logic [lspb_pkg::BYTE_W-1:0]      i_blue_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_status,
    output logic [lspb_pkg::BYTE_W-1:0]      o_first_byte,
    output logic [lspb_pkg::BYTE_W-1:0]      o_second_byte,
    output logic [lspb_pkg::BYTE_W-1:0]      o_third_byte,
    output logic                             o_last_of_run
);
    import lspb_pkg::*;

    localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cursor, n_cursor;
    logic [CNT_W-1:0]    r_pixels_in_use;
    logic [BYTE_W-1:0]   r_brightness;
    logic                r_grb_order;
    logic [CNT_W-1:0]    act_last;
    logic                cur_last;
    logic                adv;
    logic                accept;
    logic                in_range;
    t_op                 in_op;
    logic [PIX_W-1:0]    in_colour;
    logic [PIX_W-1:0]    r_fill_colour;

    logic [PIX_W-1:0]    mem [MAX_PIXELS];
    logic [MAX_PIXELS-1:0] r_valid;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [PIX_W-1:0]    mem_wdata;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [PIX_W-1:0]    r_rd_data;
    logic                r_rd_hit;

    logic                push;
    t_op                 push_op;
    logic                push_status;
    logic                push_last;

    logic                r_s1_vld;
    t_op                 r_s1_op;
    logic                r_s1_status;
    logic                r_s1_last;
    logic [PIX_W-1:0]    s1_pix;

    logic                r_s2_vld;
    t_op                 r_s2_op;
    logic                r_s2_status;
    logic                r_s2_last;
    logic [PIX_W-1:0]    r_s2_pix;
    logic [PROD_W-1:0]   r_s2_prod_r, r_s2_prod_g, r_s2_prod_b;

    logic [BYTE_W-1:0]   sc_r, sc_g, sc_b;
    logic [BYTE_W-1:0]   n_first, n_second, n_third;

    logic                r_out_valid;
    logic                r_out_status;
    logic [BYTE_W-1:0]   r_out_first, r_out_second, r_out_third;
    logic                r_out_last;

    assign in_op     = t_op'(i_operation);
    assign in_colour = {i_red_value, i_green_value, i_blue_value};
    assign adv       = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && adv;
    assign accept    = i_in_valid && o_in_ready;

    always_comb begin
        if (r_pixels_in_use == '0) begin
            act_last = '0;
        end else if (r_pixels_in_use > CNT_W'(MAX_PIXELS)) begin
            act_last = CNT_W'(MAX_PIXELS - 1);
        end else begin
            act_last = r_pixels_in_use - CNT_W'(1);
        end
    end

    assign in_range = CNT_W'(i_pixel_index) <= act_last;
    assign cur_last = CNT_W'(r_cursor) == act_last;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixels_in_use <= PIXELS_RST;
            r_brightness    <= BRIGHTNESS_RST;
            r_grb_order     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PIXELS:     r_pixels_in_use <= i_cfg_data[CNT_W-1:0];
                CFG_BRIGHTNESS: r_brightness    <= i_cfg_data[BYTE_W-1:0];
                CFG_GRB:        r_grb_order     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && in_op == OP_FILL) begin
                    n_state = ST_FILL;
                end else if (accept && in_op == OP_SHOW) begin
                    n_state = ST_SHOW;
                end
            end
            ST_FILL, ST_SHOW: begin
                if (cur_last && adv) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_cursor;
        mem_wdata   = r_fill_colour;
        rd_en       = 1'b0;
        rd_addr     = r_cursor;
        push        = 1'b0;
        push_op     = OP_SET;
        push_status = 1'b0;
        push_last   = 1'b1;
        n_cursor    = r_cursor;
        unique case (r_state)
            ST_IDLE: begin
                n_cursor = '0;
                if (accept) begin
                    unique case (in_op)
                        OP_SET: begin
                            mem_we      = in_range;
                            mem_waddr   = i_pixel_index[ADDR_W-1:0];
                            mem_wdata   = in_colour;
                            push        = 1'b1;
                            push_op     = OP_SET;
                            push_status = !in_range;
                        end
                        OP_GET: begin
                            rd_en       = in_range;
                            rd_addr     = i_pixel_index[ADDR_W-1:0];
                            push        = 1'b1;
                            push_op     = OP_GET;
                            push_status = !in_range;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FILL: begin
                mem_we  = 1'b1;
                push_op = OP_FILL;
                if (!cur_last) begin
                    n_cursor = r_cursor + ADDR_W'(1);
                end else if (adv) begin
                    push     = 1'b1;
                    n_cursor = '0;
                end
            end
            ST_SHOW: begin
                push_op   = OP_SHOW;
                push_last = cur_last;
                if (adv) begin
                    rd_en    = 1'b1;
                    push     = 1'b1;
                    n_cursor = cur_last ? '0 : r_cursor + ADDR_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cursor <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_op == OP_FILL) begin
            r_fill_colour <= in_colour;
        end
    end

    // pixel memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_hit <= r_valid[rd_addr];
            end
        end
    end

    assign s1_pix = r_rd_hit ? r_rd_data : '0;

    // pipeline: read, scale, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_vld    <= push;
            r_s2_vld    <= r_s1_vld;
            r_out_valid <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_op     <= push_op;
            r_s1_status <= push_status;
            r_s1_last   <= push_last;

            r_s2_op     <= r_s1_op;
            r_s2_status <= r_s1_status;
            r_s2_last   <= r_s1_last;
            r_s2_pix    <= s1_pix;
            r_s2_prod_r <= PROD_W'(s1_pix[PIX_W-1:2*BYTE_W]) * PROD_W'(r_brightness)
                           + ROUND_ADD;
            r_s2_prod_g <= PROD_W'(s1_pix[2*BYTE_W-1:BYTE_W]) * PROD_W'(r_brightness)
                           + ROUND_ADD;
            r_s2_prod_b <= PROD_W'(s1_pix[BYTE_W-1:0]) * PROD_W'(r_brightness)
                           + ROUND_ADD;

            r_out_status <= r_s2_status;
            r_out_last   <= r_s2_last;
            r_out_first  <= n_first;
            r_out_second <= n_second;
            r_out_third  <= n_third;
        end
    end

    assign sc_r = div255(r_s2_prod_r);
    assign sc_g = div255(r_s2_prod_g);
    assign sc_b = div255(r_s2_prod_b);

    always_comb begin
        n_first  = '0;
        n_second = '0;
        n_third  = '0;
        case (r_s2_op)
            OP_SHOW: begin
                n_first  = r_grb_order ? sc_g : sc_r;
                n_second = r_grb_order ? sc_r : sc_g;
                n_third  = sc_b;
            end
            OP_GET: begin
                if (!r_s2_status) begin
                    n_first  = r_s2_pix[PIX_W-1:2*BYTE_W];
                    n_second = r_s2_pix[2*BYTE_W-1:BYTE_W];
                    n_third  = r_s2_pix[BYTE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_first_byte  = r_out_first;
    assign o_second_byte = r_out_second;
    assign o_third_byte  = r_out_third;
    assign o_last_of_run = r_out_last;

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && rd_en))
        else $error("memory write and read in the same cycle");

    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (CNT_W'(r_cursor) <= act_last))
        else $error("walk cursor past the last active pixel");

    a_idle_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cursor == '0))
        else $error("walk cursor not parked while idle");

endmodule
